@@ hdl/sbus_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_pkg
// Shared constants and types of the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbus_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int FLAGS_AT    = FRAME_BYTES - 2;
    localparam int END_AT      = FRAME_BYTES - 1;
    localparam int DATA_BYTES  = FRAME_BYTES - 3;
    localparam int DATA_BITS   = DATA_BYTES * 8;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    localparam int RAW_W       = 11;
    localparam int ANALOG_CH   = 16;
    localparam int CH_W        = 5;
    localparam int VAL_W       = 18;
    localparam int GAIN_W      = 18;
    localparam int FRAC_SHIFT  = 12;

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam int FLAG_CH17_BIT = 0;
    localparam int FLAG_CH18_BIT = 1;
    localparam int FLAG_LOST_BIT = 2;
    localparam int FLAG_FAIL_BIT = 3;

    localparam logic [VAL_W-1:0] ONE_Q4 = VAL_W'(16);

    localparam logic [CH_W-1:0] LAST_ANALOG = CH_W'(ANALOG_CH - 1);
    localparam logic [CH_W-1:0] LAST_DIGITAL = CH_W'(ANALOG_CH + 1);

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_GAP    = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam logic [7:0]        GAP_RESET    = 8'd4;
    localparam logic [RAW_W-1:0]  OFFSET_RESET = 11'd240;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 18'd83645;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_DIG,
        ST_FS
    } sbus_state_t;

endpackage
`default_nettype wire

@@ hdl/sbus_frame_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS receiver frame decoder with channel scaling to signed Q14.4.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one received byte and the tick count
// at which it arrived. A gap above gap_limit ticks restarts framing. After the
// 25th byte of a frame with a zero end byte, the block emits either one status
// transaction (failsafe frame) or eighteen channel transactions, the last one
// marked by m_tlast.
// Bytes are taken one per cycle while the sequencer is idle, also while a
// finished result still waits on m_tready. After a channel frame completes the
// input stalls while each of the sixteen analog channels passes through the
// shared multiply and round unit (ST_MUL, then ST_RND), each digital channel
// through ST_DIG, and a failsafe frame through ST_FS. A stalled receiver holds
// the output register and the sequencer waits. Reset clears framing, the tick
// of the last byte, the active flag and output valid, and loads the register
// defaults; frame bytes are not cleared. The user must write registers over
// the APB port while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // rx_byte[7:0], now_tick[39:8]
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // channel[4:0], value[22:5], zero[23]
    output logic [3:0]       m_tuser,   // frame_lost, failsafe, status_only, active
    output logic             m_tlast
);

    localparam int CW = sbus_pkg::CNT_W;
    localparam int VW = sbus_pkg::VAL_W;
    localparam int HW = sbus_pkg::CH_W;

    sbus_pkg::sbus_state_t state_reg, state_next;

    // Configuration registers
    logic [7:0]                    gap_limit_reg;
    logic [sbus_pkg::RAW_W-1:0]    offset_reg;
    logic [sbus_pkg::GAIN_W-1:0]   gain_reg;
    logic                          cfg_wr;

    // Framing state
    logic [CW-1:0]                 byte_count_reg, byte_count_next;
    logic [31:0]                   last_time_reg, last_time_next;
    logic                          active_reg, active_next;
    logic [sbus_pkg::DATA_BITS-1:0] bits_reg, bits_next;
    logic [7:0]                    flags_reg, flags_next;
    logic                          lost_reg, lost_next;
    logic [HW-1:0]                 ch_idx_reg, ch_idx_next;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic [HW-1:0]                 out_ch_reg, out_ch_next;
    logic [VW-1:0]                 out_val_reg, out_val_next;
    logic                          out_lost_reg, out_lost_next;
    logic                          out_fs_reg, out_fs_next;
    logic                          out_st_reg, out_st_next;
    logic                          out_act_reg, out_act_next;
    logic                          out_last_reg, out_last_next;

    logic [7:0]                    rx_byte;
    logic [31:0]                   now_tick;
    logic [31:0]                   gap;
    logic [CW-1:0]                 cnt_eff;
    logic [CW-1:0]                 wr_idx;
    logic                          s_fire;
    logic                          out_free;
    logic                          mul_en;
    logic signed [VW-1:0]          scaled;

    assign rx_byte  = s_tdata[7:0];
    assign now_tick = s_tdata[39:8];
    assign s_fire   = s_tvalid && (state_reg == sbus_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign mul_en   = (state_reg == sbus_pkg::ST_MUL);

    // ---------------- Configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_limit_reg <= sbus_pkg::GAP_RESET;
            offset_reg    <= sbus_pkg::OFFSET_RESET;
            gain_reg      <= sbus_pkg::GAIN_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                sbus_pkg::REG_GAP:    gap_limit_reg <= pwdata[7:0];
                sbus_pkg::REG_OFFSET: offset_reg    <= pwdata[sbus_pkg::RAW_W-1:0];
                sbus_pkg::REG_GAIN:   gain_reg      <= pwdata[sbus_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sbus_pkg::REG_GAP:    prdata = {24'd0, gap_limit_reg};
            sbus_pkg::REG_OFFSET: prdata = {{(32 - sbus_pkg::RAW_W){1'b0}}, offset_reg};
            sbus_pkg::REG_GAIN:   prdata = {{(32 - sbus_pkg::GAIN_W){1'b0}}, gain_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // ---------------- Shared scaling unit ----------------
    sbus_scale u_scale (
        .aclk   (aclk),
        .mul_en (mul_en),
        .raw    (bits_reg[sbus_pkg::RAW_W-1:0]),
        .offset (offset_reg),
        .gain   (gain_reg),
        .value  (scaled)
    );

    // ---------------- Sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sbus_pkg::ST_IDLE;
            byte_count_reg <= '0;
            last_time_reg  <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            ch_idx_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            last_time_reg  <= last_time_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
            ch_idx_reg     <= ch_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg     <= bits_next;
        flags_reg    <= flags_next;
        lost_reg     <= lost_next;
        out_ch_reg   <= out_ch_next;
        out_val_reg  <= out_val_next;
        out_lost_reg <= out_lost_next;
        out_fs_reg   <= out_fs_next;
        out_st_reg   <= out_st_next;
        out_act_reg  <= out_act_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        last_time_next  = last_time_reg;
        active_next     = active_reg;
        bits_next       = bits_reg;
        flags_next      = flags_reg;
        lost_next       = lost_reg;
        ch_idx_next     = ch_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_ch_next     = out_ch_reg;
        out_val_next    = out_val_reg;
        out_lost_next   = out_lost_reg;
        out_fs_next     = out_fs_reg;
        out_st_next     = out_st_reg;
        out_act_next    = out_act_reg;
        out_last_next   = out_last_reg;
        s_tready        = 1'b0;

        gap     = now_tick - last_time_reg;
        cnt_eff = (gap > {24'd0, gap_limit_reg}) ? '0 : byte_count_reg;
        wr_idx  = (cnt_eff >= CW'(sbus_pkg::FRAME_BYTES)) ? '0 : cnt_eff;

        unique case (state_reg)
            sbus_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_fire) begin
                    last_time_next = now_tick;
                    if (cnt_eff == '0 && rx_byte != sbus_pkg::START_BYTE) begin
                        byte_count_next = '0;
                    end else begin
                        byte_count_next = wr_idx + CW'(1);
                        // Data bytes shift in from the top, so byte 1 ends up
                        // in the lowest bits and channel 0 in bits 10:0.
                        if (wr_idx >= CW'(1) && wr_idx <= CW'(sbus_pkg::DATA_BYTES)) begin
                            bits_next = {rx_byte, bits_reg[sbus_pkg::DATA_BITS-1:8]};
                        end
                        if (wr_idx == CW'(sbus_pkg::FLAGS_AT)) begin
                            flags_next = rx_byte;
                        end
                        if (wr_idx == CW'(sbus_pkg::END_AT)) begin
                            byte_count_next = '0;
                            lost_next = flags_reg[sbus_pkg::FLAG_LOST_BIT];
                            if (rx_byte == 8'd0) begin
                                if (flags_reg[sbus_pkg::FLAG_FAIL_BIT]) begin
                                    state_next = sbus_pkg::ST_FS;
                                end else begin
                                    active_next = 1'b1;
                                    ch_idx_next = '0;
                                    state_next  = sbus_pkg::ST_MUL;
                                end
                            end
                        end
                    end
                end
            end
            sbus_pkg::ST_MUL: begin
                state_next = sbus_pkg::ST_RND;
            end
            sbus_pkg::ST_RND: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_ch_next    = ch_idx_reg;
                    out_val_next   = scaled;
                    out_lost_next  = lost_reg;
                    out_fs_next    = 1'b0;
                    out_st_next    = 1'b0;
                    out_act_next   = 1'b1;
                    out_last_next  = 1'b0;
                    bits_next      = bits_reg >> sbus_pkg::RAW_W;
                    ch_idx_next    = ch_idx_reg + HW'(1);
                    state_next     = (ch_idx_reg == sbus_pkg::LAST_ANALOG) ?
                                     sbus_pkg::ST_DIG : sbus_pkg::ST_MUL;
                end
            end
            sbus_pkg::ST_DIG: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_ch_next    = ch_idx_reg;
                    out_val_next   = flags_reg[ch_idx_reg[0]] ? sbus_pkg::ONE_Q4 : '0;
                    out_lost_next  = lost_reg;
                    out_fs_next    = 1'b0;
                    out_st_next    = 1'b0;
                    out_act_next   = 1'b1;
                    out_last_next  = (ch_idx_reg == sbus_pkg::LAST_DIGITAL);
                    ch_idx_next    = ch_idx_reg + HW'(1);
                    if (ch_idx_reg == sbus_pkg::LAST_DIGITAL) begin
                        state_next = sbus_pkg::ST_IDLE;
                    end
                end
            end
            sbus_pkg::ST_FS: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_ch_next    = '0;
                    out_val_next   = '0;
                    out_lost_next  = lost_reg;
                    out_fs_next    = active_reg;
                    out_st_next    = 1'b1;
                    out_act_next   = active_reg;
                    out_last_next  = 1'b1;
                    state_next     = sbus_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbus_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_val_reg, out_ch_reg};
    assign m_tuser  = {out_act_reg, out_st_reg, out_fs_reg, out_lost_reg};
    assign m_tlast  = out_last_reg;

    // ---------------- Assertions ----------------
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sbus_pkg::ST_IDLE) |-> !s_tready)
        else $error("input ready while the sequencer is busy");

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_st_reg) |-> (m_tlast && out_ch_reg == '0))
        else $error("status transaction not alone in its frame");

    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_ch_reg <= sbus_pkg::LAST_DIGITAL))
        else $error("channel number out of range");

    a_channel_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_st_reg) |-> (out_act_reg && active_reg && !out_fs_reg))
        else $error("channel transaction without active flag");

    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                     $stable(m_tuser) && $stable(m_tlast)))
        else $error("result changed while the receiver stalled");

endmodule
`default_nettype wire

@@ hdl/sbus_scale.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_scale
// Shared scaling unit: (raw - offset) * gain, registered, then rounded to
// nearest with halves away from zero and saturated to signed Q14.4.
// ----------------------------------------------------------------------------
module sbus_scale (
    input  wire logic                              aclk,
    input  wire logic                              mul_en,
    input  wire logic [sbus_pkg::RAW_W-1:0]        raw,
    input  wire logic [sbus_pkg::RAW_W-1:0]        offset,
    input  wire logic [sbus_pkg::GAIN_W-1:0]       gain,
    output logic signed [sbus_pkg::VAL_W-1:0]      value
);

    localparam int D_W = sbus_pkg::RAW_W + 1;
    localparam int P_W = D_W + sbus_pkg::GAIN_W + 1;
    localparam int Q_W = P_W - sbus_pkg::FRAC_SHIFT;

    localparam logic [P_W-1:0] HALF = P_W'(1) << (sbus_pkg::FRAC_SHIFT - 1);
    localparam logic [Q_W-1:0] POS_MAX = Q_W'((1 << (sbus_pkg::VAL_W - 1)) - 1);
    localparam logic [Q_W-1:0] NEG_MAX = Q_W'(1 << (sbus_pkg::VAL_W - 1));

    logic signed [D_W-1:0] diff;
    logic signed [P_W-1:0] prod_reg;
    logic [P_W-1:0]        mag;
    logic [P_W-1:0]        mag_rnd;
    logic [Q_W-1:0]        quot;
    logic [Q_W-1:0]        quot_sat;
    logic                  neg;

    assign diff = $signed({1'b0, raw}) - $signed({1'b0, offset});

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= diff * $signed({1'b0, gain});
        end
    end

    always_comb begin
        neg     = prod_reg[P_W-1];
        mag     = neg ? P_W'(-prod_reg) : P_W'(prod_reg);
        mag_rnd = mag + HALF;
        quot    = mag_rnd[P_W-1:sbus_pkg::FRAC_SHIFT];
        if (neg) begin
            quot_sat = (quot > NEG_MAX) ? NEG_MAX : quot;
            value    = sbus_pkg::VAL_W'(-quot_sat);
        end else begin
            quot_sat = (quot > POS_MAX) ? POS_MAX : quot;
            value    = sbus_pkg::VAL_W'(quot_sat);
        end
    end

endmodule
`default_nettype wire
